/* rtl/core/ttps_pkg.sv */
// Package for the transposition table probe/store block.
// Holds parameter defaults, operation codes, bound kinds and the sequencer states.
// Has no dependencies.
package ttps_pkg;

	// Parameter defaults.
	localparam int unsigned SLOT_COUNT_DEF = 1024;
	localparam int unsigned SCORE_BITS_DEF = 16;
	localparam int unsigned MOVE_BITS_DEF  = 16;

	// Fixed widths of the interface fields.
	localparam int unsigned HASH_W  = 64;
	localparam int unsigned DEPTH_W = 7;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned AGE_W   = 8;
	localparam int unsigned WIN_W   = 16;

	// Operation codes.
	typedef enum logic [1:0] {
		FUNC_PROBE = 2'd0,
		FUNC_STORE = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// Bound kinds of a stored entry.
	localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UPPER = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;

	// Sequencer states, one-hot.
	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_CLEAR = 2'b10
	} state_t;

endpackage

/* rtl/core/ttps_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// A read of the address being written returns the old contents.
// Has no dependencies.
module ttps_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/core/transposition_table_probe_store.sv */
// Top level of the direct-mapped transposition table: probe, store and clear.
// Depends on ttps_pkg and ttps_ram.
//
//  Channel   Handshake                 Carries
//  --------  ------------------------  -------------------------------------------------
//  command   start, busy               func, position_hash, search_depth, alpha_bound,
//                                      beta_bound, new_score, new_move, new_bound_kind
//  result    done (one-cycle strobe)   found, cutoff_usable, entry_move, entry_score,
//                                      entry_depth, entry_bound_kind, was_written,
//                                      was_collision
//  config    cfg_valid, cfg_ready      search_age
//
// A probe or store reads the slot in the cycle it is accepted, evaluates and writes back
// in the next cycle, and strobes done in the cycle after that; one command is taken per
// cycle while busy is low. Back-to-back commands to the same slot are served by forwarding
// the pending write. A clear walks the table at one slot per cycle: busy stays high until
// the last slot is written and done follows the last slot. After reset the same sweep runs
// with busy high and gives no result. Results cannot be stalled by the receiver.
module transposition_table_probe_store #(
	parameter int unsigned SLOT_COUNT = ttps_pkg::SLOT_COUNT_DEF,
	parameter int unsigned SCORE_BITS = ttps_pkg::SCORE_BITS_DEF,
	parameter int unsigned MOVE_BITS  = ttps_pkg::MOVE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel.
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [63:0] position_hash,
	input  logic [6:0]  search_depth,
	input  logic signed [15:0] alpha_bound,
	input  logic signed [15:0] beta_bound,
	input  logic signed [15:0] new_score,
	input  logic [15:0] new_move,
	input  logic [1:0]  new_bound_kind,
	// Result channel.
	output logic        done,
	output logic        found,
	output logic        cutoff_usable,
	output logic [15:0] entry_move,
	output logic signed [15:0] entry_score,
	output logic [6:0]  entry_depth,
	output logic [1:0]  entry_bound_kind,
	output logic        was_written,
	output logic        was_collision,
	// Configuration channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  search_age
);

	localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
	localparam int unsigned HASH_W = ttps_pkg::HASH_W;
	localparam int unsigned DEPTH_W = ttps_pkg::DEPTH_W;
	localparam int unsigned KIND_W = ttps_pkg::KIND_W;
	localparam int unsigned AGE_W = ttps_pkg::AGE_W;
	localparam int unsigned WIN_W = ttps_pkg::WIN_W;

	// Entry layout, low to high: age, kind, depth, score, move, hash.
	localparam int unsigned AGE_LO   = 0;
	localparam int unsigned KIND_LO  = AGE_LO + AGE_W;
	localparam int unsigned DEPTH_LO = KIND_LO + KIND_W;
	localparam int unsigned SCORE_LO = DEPTH_LO + DEPTH_W;
	localparam int unsigned MOVE_LO  = SCORE_LO + SCORE_BITS;
	localparam int unsigned HASH_LO  = MOVE_LO + MOVE_BITS;
	localparam int unsigned ENTRY_W  = HASH_LO + HASH_W;

	// Working widths for score and move conversion, wider than any legal field.
	localparam int unsigned EXT_W = 34;
	localparam int unsigned MV_EXT_W = 33;
	localparam logic signed [EXT_W-1:0] SCORE_MAX =
		EXT_W'((longint'(1) << (SCORE_BITS - 1)) - 1);
	localparam logic signed [EXT_W-1:0] SCORE_MIN = ~SCORE_MAX;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	ttps_pkg::state_t state_q;
	logic [IDX_W-1:0] clr_ptr_q;
	logic             clr_report_q;
	logic [AGE_W-1:0] age_q;
	logic             accept;
	logic [IDX_W-1:0] in_idx;

	// Stage 1 registers: the command whose slot data arrives this cycle.
	logic                    valid_s1;
	ttps_pkg::func_t         func_s1;
	logic [HASH_W-1:0]       hash_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [DEPTH_W-1:0]      depth_s1;
	logic signed [WIN_W-1:0] alpha_s1;
	logic signed [WIN_W-1:0] beta_s1;
	logic [SCORE_BITS-1:0]   score_s1;
	logic [MOVE_BITS-1:0]    move_s1;
	logic [KIND_W-1:0]       kind_s1;
	logic                    fwd_s1;
	logic [ENTRY_W-1:0]      fwd_data_s1;

	// Input conversion.
	logic signed [EXT_W-1:0] new_score_ext;
	logic [SCORE_BITS-1:0]   new_score_fit;
	logic [MV_EXT_W-1:0]     new_move_ext;

	// Slot access.
	logic [ENTRY_W-1:0] ram_rd_data;
	logic [ENTRY_W-1:0] entry;
	logic               ram_wr_en;
	logic [IDX_W-1:0]   ram_wr_addr;
	logic [ENTRY_W-1:0] ram_wr_data;
	logic               s1_wr_en;
	logic [ENTRY_W-1:0] s1_wr_data;

	// Fields of the entry being evaluated.
	logic [HASH_W-1:0]      e_hash;
	logic [MOVE_BITS-1:0]   e_move;
	logic [SCORE_BITS-1:0]  e_score;
	logic [DEPTH_W-1:0]     e_depth;
	logic [KIND_W-1:0]      e_kind;
	logic [AGE_W-1:0]       e_age;
	logic signed [EXT_W-1:0] e_score_ext;
	logic signed [EXT_W-1:0] alpha_ext;
	logic signed [EXT_W-1:0] beta_ext;
	logic [MV_EXT_W-1:0]    e_move_ext;

	// Evaluation results.
	logic                    hit;
	logic                    use_entry;
	logic signed [EXT_W-1:0] out_score_ext;
	logic                    replace;
	logic                    collide;

	// Output registers.
	logic                    done_q;
	logic                    found_q;
	logic                    cutoff_q;
	logic [WIN_W-1:0]        move_q;
	logic [WIN_W-1:0]        score_q;
	logic [DEPTH_W-1:0]      depth_q;
	logic [KIND_W-1:0]       kind_q;
	logic                    written_q;
	logic                    collision_q;

	assign busy      = (state_q == ttps_pkg::ST_CLEAR);
	assign accept    = start && !busy;
	assign in_idx    = position_hash[IDX_W-1:0];
	assign cfg_ready = 1'b1;

	// Saturate the new score to the stored width and fit the move word.
	always_comb begin
		new_score_ext = {{(EXT_W - WIN_W){new_score[WIN_W-1]}}, new_score};
		if (new_score_ext > SCORE_MAX) begin
			new_score_fit = SCORE_MAX[SCORE_BITS-1:0];
		end else if (new_score_ext < SCORE_MIN) begin
			new_score_fit = SCORE_MIN[SCORE_BITS-1:0];
		end else begin
			new_score_fit = new_score_ext[SCORE_BITS-1:0];
		end
		new_move_ext = {{(MV_EXT_W - WIN_W){1'b0}}, new_move};
	end

	// Sequencer: normal operation or a clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ttps_pkg::ST_CLEAR;
			clr_ptr_q    <= '0;
			clr_report_q <= 1'b0;
			age_q        <= '0;
		end else begin
			unique case (state_q)
				ttps_pkg::ST_RUN: begin
					if (accept && func == ttps_pkg::FUNC_CLEAR) begin
						state_q      <= ttps_pkg::ST_CLEAR;
						clr_ptr_q    <= '0;
						clr_report_q <= 1'b1;
						age_q        <= '0;
					end else if (cfg_valid) begin
						age_q <= search_age;
					end
				end
				ttps_pkg::ST_CLEAR: begin
					if (clr_ptr_q == LAST_IDX) begin
						state_q      <= ttps_pkg::ST_RUN;
						clr_ptr_q    <= '0;
						clr_report_q <= 1'b0;
					end else begin
						clr_ptr_q <= clr_ptr_q + 1'b1;
					end
					if (cfg_valid) begin
						age_q <= search_age;
					end
				end
				default: begin
					state_q <= ttps_pkg::ST_RUN;
				end
			endcase
		end
	end

	// Stage 1 valid; a clear does not enter the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept && (func != ttps_pkg::FUNC_CLEAR);
			fwd_s1   <= accept && (func != ttps_pkg::FUNC_CLEAR) && s1_wr_en &&
				(idx_s1 == in_idx);
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= ttps_pkg::func_t'(func);
			hash_s1     <= position_hash;
			idx_s1      <= in_idx;
			depth_s1    <= search_depth;
			alpha_s1    <= alpha_bound;
			beta_s1     <= beta_bound;
			score_s1    <= new_score_fit;
			move_s1     <= new_move_ext[MOVE_BITS-1:0];
			kind_s1     <= new_bound_kind;
			fwd_data_s1 <= s1_wr_data;
		end
	end

	// Slot data, taking the pending write when it targets the same slot.
	always_comb begin
		entry   = fwd_s1 ? fwd_data_s1 : ram_rd_data;
		e_hash  = entry[HASH_LO +: HASH_W];
		e_move  = entry[MOVE_LO +: MOVE_BITS];
		e_score = entry[SCORE_LO +: SCORE_BITS];
		e_depth = entry[DEPTH_LO +: DEPTH_W];
		e_kind  = entry[KIND_LO +: KIND_W];
		e_age   = entry[AGE_LO +: AGE_W];
		e_score_ext = {{(EXT_W - SCORE_BITS){e_score[SCORE_BITS-1]}}, e_score};
		alpha_ext   = {{(EXT_W - WIN_W){alpha_s1[WIN_W-1]}}, alpha_s1};
		beta_ext    = {{(EXT_W - WIN_W){beta_s1[WIN_W-1]}}, beta_s1};
		e_move_ext  = {{(MV_EXT_W - MOVE_BITS){1'b0}}, e_move};
	end

	// Probe evaluation: hit, depth check and window decision.
	always_comb begin
		hit           = (e_hash == hash_s1);
		use_entry     = 1'b0;
		out_score_ext = e_score_ext;
		if (e_depth >= depth_s1) begin
			case (e_kind)
				ttps_pkg::KIND_EXACT: begin
					use_entry = 1'b1;
				end
				ttps_pkg::KIND_UPPER: begin
					if (e_score_ext <= alpha_ext) begin
						use_entry     = 1'b1;
						out_score_ext = alpha_ext;
					end
				end
				ttps_pkg::KIND_LOWER: begin
					if (e_score_ext >= beta_ext) begin
						use_entry     = 1'b1;
						out_score_ext = beta_ext;
					end
				end
				default: begin
					use_entry = 1'b0;
				end
			endcase
		end
	end

	// Store evaluation: replacement rule and write-back data.
	always_comb begin
		replace = (e_hash == '0) || (e_hash == hash_s1) || (depth_s1 >= e_depth) ||
			(e_age != age_q);
		collide = (e_hash != '0) && (e_hash != hash_s1);
		s1_wr_en = valid_s1 && (func_s1 == ttps_pkg::FUNC_STORE) && replace;
		s1_wr_data = {hash_s1, move_s1, score_s1, depth_s1, kind_s1, age_q};
	end

	// Write port: the clearing sweep or the stage 1 write-back.
	always_comb begin
		if (state_q == ttps_pkg::ST_CLEAR) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_ptr_q;
			ram_wr_data = '0;
		end else begin
			ram_wr_en   = s1_wr_en;
			ram_wr_addr = idx_s1;
			ram_wr_data = s1_wr_data;
		end
	end

	ttps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT),
		.ADDR_W(IDX_W)
	) u_slots (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(in_idx),
		.rd_data(ram_rd_data)
	);

	// Result strobe: one per stage 1 transaction, one at the end of a requested clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1 ||
				(state_q == ttps_pkg::ST_CLEAR && clr_ptr_q == LAST_IDX && clr_report_q);
		end
	end

	// Result fields; everything reads zero where it does not apply.
	always_ff @(posedge clk) begin
		found_q     <= 1'b0;
		cutoff_q    <= 1'b0;
		move_q      <= '0;
		score_q     <= '0;
		depth_q     <= '0;
		kind_q      <= '0;
		written_q   <= 1'b0;
		collision_q <= 1'b0;
		if (valid_s1) begin
			unique case (func_s1)
				ttps_pkg::FUNC_PROBE: begin
					if (hit) begin
						found_q  <= 1'b1;
						cutoff_q <= use_entry;
						move_q   <= e_move_ext[WIN_W-1:0];
						score_q  <= out_score_ext[WIN_W-1:0];
						depth_q  <= e_depth;
						kind_q   <= e_kind;
					end
				end
				ttps_pkg::FUNC_STORE: begin
					written_q   <= replace;
					collision_q <= replace && collide;
				end
				default: begin
					found_q <= 1'b0;
				end
			endcase
		end
	end

	assign done             = done_q;
	assign found            = found_q;
	assign cutoff_usable    = cutoff_q;
	assign entry_move       = move_q;
	assign entry_score      = score_q;
	assign entry_depth      = depth_q;
	assign entry_bound_kind = kind_q;
	assign was_written      = written_q;
	assign was_collision    = collision_q;

	// The sweep owns the write port: no stage 1 transaction is pending while clearing.
	a_no_s1_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttps_pkg::ST_CLEAR) |-> !valid_s1)
		else $error("stage 1 transaction pending during clearing sweep");

	// Every result comes from stage 1 or from the last slot of a clear.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(valid_s1) || $past(state_q == ttps_pkg::ST_CLEAR)))
		else $error("result strobe without a source");

	// Forwarding is only armed by a write-back of the previous transaction.
	a_fwd_cause: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> ($past(s1_wr_en) && valid_s1))
		else $error("forwarded entry without a preceding write");

	// A collision is only reported with a replacement.
	a_collision_written: assert property (@(posedge clk) disable iff (!arst_n)
		collision_q |-> written_q)
		else $error("collision reported without a write");

	// A usable cutoff implies a hit.
	a_cutoff_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cutoff_q |-> found_q)
		else $error("cutoff reported on a miss");

endmodule
